/* hw/rtl/dlfr_pkg.sv */
// shared types and constants of the delimited length frame receiver
// used by dlfr_front, dlfr_queue, dlfr_back and the top level
package dlfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAME_DEPTH_DEF = 26;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd40;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd41;
  localparam logic [POS_W-1:0]  MIN_LEN_RST    = 5'd5;
  localparam logic [POS_W-1:0]  MAX_LEN_RST    = 5'd25;
  localparam logic [POS_W-1:0]  POS_LIMIT      = 5'd31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd3;

  // one finished frame waiting to be drained
  typedef struct packed {
    logic             bank;
    logic [POS_W-1:0] last_pos;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    logic     full;
    q_entry_t head;
  } q_stat_t;

  // frame buffer write from the front
  typedef struct packed {
    logic              wr_en;
    logic              bank;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

/* hw/rtl/delimited_length_frame_receiver_top.sv */
// top level of the delimited length frame receiver
// depends on dlfr_pkg, dlfr_front, dlfr_queue, dlfr_back
//
// usage
//   input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per item. a start byte opens a frame, the next byte is its length L, and
//   an end byte at position L closes it. the closed frame comes out on the
//   result channel (out_valid / out_stall / out_*) as L+1 items, position 0
//   first, with out_last_of_frame set on the closing byte. invalid lengths
//   and overlong frames are dropped without results.
//   cfg_wr_en / cfg_index / cfg_wdata write start_char, end_char, min_length
//   and max_length; write them only while the block is idle.
// timing
//   the front takes one byte every cycle while not stalled; its stall rises only
//   while both buffer banks hold closed frames that are not yet drained.
//   the drain reads the frame buffer one byte at a time, each in a memory
//   read state and then an output register state; the next byte is read
//   only after the shown one is taken.
//   reset returns all control state to idle and the registers to defaults;
//   the buffer needs no clearing pass. a stalled result holds its payload
//   while the front keeps collecting the next frame into the other bank.
module delimited_length_frame_receiver_top
  import dlfr_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  // received bytes
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // frame bytes
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_frame_byte,
  output logic [POS_W-1:0]     out_byte_position,
  output logic                 out_last_of_frame
);

  q_push_t q_push;
  q_stat_t q_stat;
  mem_wr_t mem_wr;
  logic    q_pop;

  // parser writes the free bank and posts closed frames
  dlfr_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .mem_wr     (mem_wr)
  );

  // closed frames waiting for the drain, one per buffer bank
  dlfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_stat (q_stat)
  );

  // buffer owner and result sequencer
  dlfr_back #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_wr            (mem_wr),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_of_frame (out_last_of_frame)
  );

  // a closed frame is never posted into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !q_stat.full)
    else $error("frame posted while queue full");

  // the front never writes the bank that is being drained
  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.wr_en && q_stat.valid) |-> (mem_wr.bank != q_stat.head.bank))
    else $error("buffer write into bank under drain");

  // results only come from a posted frame
  a_out_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> q_stat.valid)
    else $error("result shown with no frame pending");

  // the last item of a frame frees its queue slot
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_frame) |-> q_pop)
    else $error("last item taken without releasing its frame");

endmodule

/* hw/rtl/dlfr_front.sv */
// front part: configuration registers, frame parser, buffer writes
// depends on dlfr_pkg
module dlfr_front
  import dlfr_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  q_stat_t              q_stat,
  output q_push_t              q_push,
  output mem_wr_t              mem_wr
);

  localparam logic [6:0] DEPTH_V = 7'(FRAME_DEPTH);

  logic [BYTE_W-1:0] start_char_r;
  logic [BYTE_W-1:0] end_char_r;
  logic [POS_W-1:0]  min_len_r;
  logic [POS_W-1:0]  max_len_r;

  logic             coll_r, coll_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic             bank_r, bank_nxt;

  logic       acc;
  logic       len_bad;
  logic       pos_over;
  logic [6:0] pos_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
      min_len_r    <= MIN_LEN_RST;
      max_len_r    <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_CHAR: start_char_r <= cfg_wdata;
        CFG_END_CHAR:   end_char_r   <= cfg_wdata;
        CFG_MIN_LENGTH: min_len_r    <= cfg_wdata[POS_W-1:0];
        CFG_MAX_LENGTH: max_len_r    <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // both buffer banks hold frames still to drain
  assign in_stall = q_stat.full;
  assign acc      = in_valid && !in_stall;

  assign pos_ext  = {2'b00, pos_r};
  assign len_bad  = (in_rx_byte < {3'b000, min_len_r}) || (in_rx_byte > {3'b000, max_len_r});
  assign pos_over = (pos_r > max_len_r) || (pos_ext >= DEPTH_V) || (pos_r >= POS_LIMIT);

  always_comb begin
    coll_nxt     = coll_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    bank_nxt     = bank_r;
    q_push       = '0;
    mem_wr.wr_en = 1'b0;
    mem_wr.bank  = bank_r;
    mem_wr.pos   = pos_r;
    mem_wr.data  = in_rx_byte;
    if (acc) begin
      if (!coll_r) begin
        if (in_rx_byte == start_char_r) begin
          coll_nxt     = 1'b1;
          mem_wr.wr_en = 1'b1;
          mem_wr.pos   = '0;
          pos_nxt      = 5'd1;
        end
      end else if (pos_r == 5'd1) begin
        // length byte never closes the frame
        if (len_bad) begin
          coll_nxt = 1'b0;
          pos_nxt  = '0;
        end else begin
          len_nxt      = in_rx_byte[POS_W-1:0];
          mem_wr.wr_en = 1'b1;
          pos_nxt      = 5'd2;
        end
      end else if ((in_rx_byte == end_char_r) && (pos_r == len_r) && (pos_ext < DEPTH_V)) begin
        mem_wr.wr_en           = 1'b1;
        q_push.push            = 1'b1;
        q_push.entry.bank      = bank_r;
        q_push.entry.last_pos  = pos_r;
        bank_nxt               = !bank_r;
        coll_nxt               = 1'b0;
        pos_nxt                = '0;
      end else if (pos_over) begin
        coll_nxt = 1'b0;
        pos_nxt  = '0;
      end else begin
        mem_wr.wr_en = 1'b1;
        pos_nxt      = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= 1'b0;
      pos_r  <= '0;
      len_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      coll_r <= coll_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

/* hw/rtl/dlfr_queue.sv */
// two entry queue of finished frames between front and back
// depends on dlfr_pkg
module dlfr_queue
  import dlfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    q_pop,
  output q_stat_t q_stat
);

  q_entry_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      ent_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (q_push.push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      case ({q_push.push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign q_stat.valid = (cnt_r != 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.head  = ent_r[rd_ptr_r];

endmodule

/* hw/rtl/dlfr_back.sv */
// back part: two bank frame buffer and the result drain sequencer
// depends on dlfr_pkg
module dlfr_back
  import dlfr_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_wr_t           mem_wr,
  input  q_stat_t           q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_frame_byte,
  output logic [POS_W-1:0]  out_byte_position,
  output logic              out_last_of_frame
);

  localparam int IDX_W  = $clog2(FRAME_DEPTH);
  localparam int ADDR_W = IDX_W + 1;
  localparam int MEM_D  = 2 ** ADDR_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_SHOW = 2'd2;

  logic [BYTE_W-1:0] mem [MEM_D];
  logic [BYTE_W-1:0] rdata_r;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] last_r, last_nxt;
  logic             bank_r, bank_nxt;

  logic              rd_en;
  logic [6:0]        wr_ext;
  logic [6:0]        rd_ext;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_ext  = {2'b00, mem_wr.pos};
  assign rd_ext  = {2'b00, cnt_r};
  assign wr_addr = {mem_wr.bank, wr_ext[IDX_W-1:0]};
  assign rd_addr = {bank_r, rd_ext[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_wr.wr_en) begin
      mem[wr_addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    bank_nxt  = bank_r;
    rd_en     = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_stat.valid) begin
          bank_nxt  = q_stat.head.bank;
          last_nxt  = q_stat.head.last_pos;
          cnt_nxt   = '0;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        rd_en     = 1'b1;
        state_nxt = B_SHOW;
      end
      B_SHOW: begin
        if (!out_stall) begin
          if (cnt_r == last_r) begin
            q_pop     = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 5'd1;
            state_nxt = B_READ;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      last_r  <= '0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      bank_r  <= bank_nxt;
    end
  end

  assign out_valid         = (state_r == B_SHOW);
  assign out_frame_byte    = rdata_r;
  assign out_byte_position = cnt_r;
  assign out_last_of_frame = (cnt_r == last_r);

endmodule
